// ----- rtl/aedf_pkg.sv -----
// Shared types and constants for the adaptive EMA dead-band filter.
// No dependencies; every other file of the block imports this package.
package aedf_pkg;

	localparam int CNT_W        = 24;
	localparam int UNITS_W      = 16;
	localparam int WEIGHT_W     = 8;
	localparam int WEIGHT_SHIFT = 8;
	localparam int CFG_W        = 24;
	localparam int CFG_IDX_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNITS_DIVISOR = 3'd6;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 8'd255;
	localparam logic [CNT_W-1:0]    DIVISOR_RESET = 24'd1;

	typedef struct packed {
		logic [CNT_W-1:0]    error_low;
		logic [CNT_W-1:0]    error_high;
		logic [WEIGHT_W-1:0] weight_min;
		logic [WEIGHT_W-1:0] weight_max;
		logic [CNT_W-1:0]    dead_band;
		logic [CNT_W-1:0]    zero_offset;
		logic [CNT_W-1:0]    units_divisor;
	} cfg_t;

	typedef struct packed {
		logic                      valid;
		logic [CNT_W-1:0]          filtered_count;
		logic signed [UNITS_W-1:0] filtered_units;
		logic signed [UNITS_W-1:0] raw_units;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_WSEL,
		ST_WMUL,
		ST_WDIV_GO,
		ST_WDIV_WAIT,
		ST_SMUL,
		ST_UPD,
		ST_HOLD,
		ST_FDIV_GO,
		ST_FDIV_WAIT,
		ST_RDIV_GO,
		ST_RDIV_WAIT,
		ST_DONE
	} aedf_state_t;

endpackage

// ----- rtl/aedf_div.sv -----
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Shared by the weight interpolation and both unit conversions; uses aedf_pkg.
module aedf_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	import aedf_pkg::*;

	localparam int CNT_BITS = $clog2(NUM_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_W-1:0]    rem_q;
	logic [DEN_W-1:0]    den_q;
	logic [NUM_W-1:0]    quo_q;

	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_sub;

	always_comb begin
		rem_sh  = {rem_q, quo_q[NUM_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/aedf_calc.sv -----
// Sequencer and datapath for one sample: weight choice, smoothing update,
// dead band and the two unit conversions. Uses aedf_pkg and aedf_div.
module aedf_calc #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [aedf_pkg::CNT_W-1:0]  sample,
	input  aedf_pkg::cfg_t              cfg,
	input  logic                        res_ready,
	output logic                        idle,
	output aedf_pkg::res_t              res
);
	import aedf_pkg::*;

	localparam int SW  = SAMPLE_BITS;
	localparam int CW  = (SW > CNT_W) ? SW : CNT_W;
	localparam int MAW = CW + 1;
	localparam int PW  = MAW + WEIGHT_W + 1;
	localparam int DW  = (CW > CNT_W + WEIGHT_W) ? CW : CNT_W + WEIGHT_W;

	aedf_state_t state_q, state_d;

	logic                        primed_q;
	logic [SW-1:0]               x_q;
	logic [SW-1:0]               sm_q;
	logic [SW-1:0]               held_q;
	logic [SW-1:0]               err_q;
	logic signed [SW:0]          diff_q;
	logic [WEIGHT_W-1:0]         w_q;
	logic signed [PW-1:0]        prod_q;
	logic                        neg_q;
	logic signed [UNITS_W-1:0]   fu_q;
	logic signed [UNITS_W-1:0]   ru_q;

	logic [CW-1:0]               err_c;
	logic [CW-1:0]               el_c;
	logic [CW-1:0]               eh_c;
	logic signed [MAW-1:0]       mul_a;
	logic signed [WEIGHT_W:0]    mul_b;
	logic signed [PW-1:0]        mul_p;
	logic signed [PW-1:0]        prod_abs;
	logic signed [PW-1:0]        step;
	logic [SW-1:0]               hold_gap;
	logic [SW-1:0]               cnt_src;
	logic signed [MAW-1:0]       units_num;
	logic [MAW-1:0]              units_mag;
	logic                        div_start;
	logic [DW-1:0]               div_num;
	logic [CNT_W-1:0]            div_den;
	logic                        div_done;
	logic [DW-1:0]               div_quo;
	logic                        divisor_zero;
	logic signed [UNITS_W-1:0]   units_q;

	aedf_div #(
		.NUM_W (DW),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Shared operand selection for the multiplier and the divider.
	always_comb begin
		err_c = CW'(err_q);
		el_c  = CW'(cfg.error_low);
		eh_c  = CW'(cfg.error_high);

		if (state_q == ST_WMUL) begin
			mul_a = $signed({1'b0, err_c - el_c});
			mul_b = $signed({1'b0, cfg.weight_max}) - $signed({1'b0, cfg.weight_min});
		end else begin
			mul_a = MAW'(diff_q);
			mul_b = $signed({1'b0, w_q});
		end
		mul_p = mul_a * mul_b;

		prod_abs = prod_q[PW-1] ? -prod_q : prod_q;
		step     = prod_q >>> WEIGHT_SHIFT;
		hold_gap = (sm_q > held_q) ? (sm_q - held_q) : (held_q - sm_q);

		cnt_src   = (state_q == ST_FDIV_GO) ? held_q : x_q;
		units_num = $signed({1'b0, CW'(cnt_src)}) - $signed({1'b0, CW'(cfg.zero_offset)});
		units_mag = units_num[MAW-1] ? 
			MAW'(-units_num) : MAW'(units_num);
		divisor_zero = cfg.units_divisor == '0;

		if (state_q == ST_WDIV_GO) begin
			div_num = prod_abs[DW-1:0];
			div_den = cfg.error_high - cfg.error_low;
		end else begin
			div_num = DW'(units_mag);
			div_den = cfg.units_divisor;
		end

		units_q = neg_q ? -$signed(div_quo[UNITS_W-1:0]) : $signed(div_quo[UNITS_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		idle      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					state_d = primed_q ? ST_ERR : ST_FDIV_GO;
				end
			end
			ST_ERR: begin
				state_d = ST_WSEL;
			end
			ST_WSEL: begin
				priority if (err_c <= el_c) begin
					state_d = ST_SMUL;
				end else if (err_c >= eh_c) begin
					state_d = ST_SMUL;
				end else begin
					state_d = ST_WMUL;
				end
			end
			ST_WMUL: begin
				state_d = ST_WDIV_GO;
			end
			ST_WDIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_WDIV_WAIT;
			end
			ST_WDIV_WAIT: begin
				if (div_done) begin
					state_d = ST_SMUL;
				end
			end
			ST_SMUL: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = ST_HOLD;
			end
			ST_HOLD: begin
				state_d = ST_FDIV_GO;
			end
			ST_FDIV_GO: begin
				div_start = !divisor_zero;
				state_d   = divisor_zero ? ST_RDIV_GO : ST_FDIV_WAIT;
			end
			ST_FDIV_WAIT: begin
				if (div_done) begin
					state_d = ST_RDIV_GO;
				end
			end
			ST_RDIV_GO: begin
				div_start = !divisor_zero;
				state_d   = divisor_zero ? ST_DONE : ST_RDIV_WAIT;
			end
			ST_RDIV_WAIT: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			sm_q     <= '0;
			held_q   <= '0;
		end else begin
			if (state_q == ST_IDLE && start && !primed_q) begin
				primed_q <= 1'b1;
				sm_q     <= SW'(sample);
				held_q   <= SW'(sample);
			end
			if (state_q == ST_UPD) begin
				sm_q <= sm_q + step[SW-1:0];
			end
			if (state_q == ST_HOLD && CW'(hold_gap) > CW'(cfg.dead_band)) begin
				held_q <= sm_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q <= SW'(sample);
			end
			ST_ERR: begin
				err_q  <= (x_q > sm_q) ? (x_q - sm_q) : (sm_q - x_q);
				diff_q <= $signed({1'b0, x_q}) - $signed({1'b0, sm_q});
			end
			ST_WSEL: begin
				// Low threshold is tested first, so out-of-order thresholds
				// still select one of the two end weights.
				w_q <= (err_c <= el_c) ? cfg.weight_min : cfg.weight_max;
			end
			ST_WMUL, ST_SMUL: begin
				prod_q <= mul_p;
			end
			ST_WDIV_GO: begin
				neg_q <= prod_q[PW-1];
			end
			ST_WDIV_WAIT: begin
				if (div_done) begin
					w_q <= neg_q ? cfg.weight_min - div_quo[WEIGHT_W-1:0]
					             : cfg.weight_min + div_quo[WEIGHT_W-1:0];
				end
			end
			ST_FDIV_GO: begin
				neg_q <= units_num[MAW-1];
				if (divisor_zero) begin
					fu_q <= '0;
				end
			end
			ST_FDIV_WAIT: begin
				if (div_done) begin
					fu_q <= units_q;
				end
			end
			ST_RDIV_GO: begin
				neg_q <= units_num[MAW-1];
				if (divisor_zero) begin
					ru_q <= '0;
				end
			end
			ST_RDIV_WAIT: begin
				if (div_done) begin
					ru_q <= units_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.valid          = state_q == ST_DONE;
		res.filtered_count = CNT_W'(held_q);
		res.filtered_units = fu_q;
		res.raw_units      = ru_q;
	end

endmodule

// ----- rtl/adaptive_ema_deadband_filter.sv -----
// Top level of the adaptive EMA dead-band filter: configuration registers,
// input handshake and output register. Uses aedf_pkg and aedf_calc.
//
// One sample enters per transaction and yields one result transaction. The
// block works on one sample at a time and needs at most three divisions, all
// made by the serial divider that computes one quotient bit per cycle and
// serves the weight interpolation and both unit conversions in turn.
// A sample whose weight is not interpolated needs two divisions, and the
// first sample after reset needs only the two unit divisions; a zero
// units_divisor skips the unit divisions. A finished result waits in the
// output register, so the next sample can be taken while it is stalled.
// Register writes are applied at once and should only be made while the
// block is idle.
module adaptive_ema_deadband_filter #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [aedf_pkg::CNT_W-1:0]        sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [aedf_pkg::CNT_W-1:0]        filtered_count,
	output logic signed [aedf_pkg::UNITS_W-1:0] filtered_units,
	output logic signed [aedf_pkg::UNITS_W-1:0] raw_units,
	input  logic                              cfg_we,
	input  logic [aedf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aedf_pkg::CFG_W-1:0]        cfg_data
);
	import aedf_pkg::*;

	cfg_t cfg_q;
	res_t res;
	logic core_idle;
	logic res_ready;
	logic out_valid_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [UNITS_W-1:0] fu_q;
	logic signed [UNITS_W-1:0] ru_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_low     <= '0;
			cfg_q.error_high    <= '0;
			cfg_q.weight_min    <= WEIGHT_RESET;
			cfg_q.weight_max    <= WEIGHT_RESET;
			cfg_q.dead_band     <= '0;
			cfg_q.zero_offset   <= '0;
			cfg_q.units_divisor <= DIVISOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ERROR_LOW:     cfg_q.error_low     <= cfg_data;
				REG_ERROR_HIGH:    cfg_q.error_high    <= cfg_data;
				REG_WEIGHT_MIN:    cfg_q.weight_min    <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_MAX:    cfg_q.weight_max    <= cfg_data[WEIGHT_W-1:0];
				REG_DEAD_BAND:     cfg_q.dead_band     <= cfg_data;
				REG_ZERO_OFFSET:   cfg_q.zero_offset   <= cfg_data;
				REG_UNITS_DIVISOR: cfg_q.units_divisor <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	aedf_calc #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && !in_stall),
		.sample    (sample),
		.cfg       (cfg_q),
		.res_ready (res_ready),
		.idle      (core_idle),
		.res       (res)
	);

	assign in_stall  = !core_idle;
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			count_q <= res.filtered_count;
			fu_q    <= res.filtered_units;
			ru_q    <= res.raw_units;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_count = count_q;
	assign filtered_units = fu_q;
	assign raw_units      = ru_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sample accepted while the block did not go busy");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && out_valid_q && out_stall |=> res.valid)
		else $error("finished result dropped while the output was stalled");

	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(res.valid))
		else $error("output became valid without a finished result");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for adaptive_ema_deadband_filter: directed and random samples,
// random gaps and back-pressure, each result checked against an in-bench prediction.
// Depends on aedf_pkg and the filter RTL.
module tb;
	import aedf_pkg::*;

	localparam int WATCHDOG_CYCLES = 12000;
	localparam int HOLD_CYCLES     = 2000;
	localparam int SETTLE_CYCLES   = 20;
	localparam int TAIL_CYCLES     = 200;
	localparam int RANDOM_PHASES   = 12;
	localparam int PHASE_SAMPLES   = 105;
	localparam int BURST_SAMPLES   = 24;
	localparam longint COUNT_TOP   = 64'hFF_FFFF;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [CNT_W-1:0]          count;
		logic signed [UNITS_W-1:0] filtered_units;
		logic signed [UNITS_W-1:0] raw_units;
	} reading_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [CNT_W-1:0]          sample = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [CNT_W-1:0]          filtered_count;
	logic signed [UNITS_W-1:0] filtered_units;
	logic signed [UNITS_W-1:0] raw_units;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]          cfg_data = '0;

	bit hold_request = 1'b0;
	bit pace_enable = 1'b1;

	// Shadow copy of the filter state and its registers.
	cfg_t             shadow_cfg;
	bit               shadow_primed;
	logic [CNT_W-1:0] shadow_smoothed;
	logic [CNT_W-1:0] shadow_held;

	reading_t expected_readings[$];

	int mismatches = 0;
	int results_checked = 0;
	int samples_sent = 0;
	int cfg_writes = 0;
	int interpolated = 0;
	int held_moves = 0;
	int quiet_cycles = 0;

	adaptive_ema_deadband_filter dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!pace_enable || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 150);
	endfunction

	function automatic logic signed [UNITS_W-1:0] count_to_units(input logic [CNT_W-1:0] count);
		longint num, den, quot;
		if (shadow_cfg.units_divisor == '0)
			return '0;
		num = count;
		den = shadow_cfg.zero_offset;
		num = num - den;
		den = shadow_cfg.units_divisor;
		quot = num / den;
		return quot[UNITS_W-1:0];
	endfunction

	function automatic longint smoothing_weight(input longint err);
		longint lo, hi, wmin, wmax;
		lo = shadow_cfg.error_low;
		hi = shadow_cfg.error_high;
		wmin = shadow_cfg.weight_min;
		wmax = shadow_cfg.weight_max;
		// With the thresholds out of order the low test wins, so no division happens.
		if (err <= lo)
			return wmin;
		if (err >= hi)
			return wmax;
		interpolated++;
		return wmin + ((err - lo) * (wmax - wmin)) / (hi - lo);
	endfunction

	function automatic reading_t predict_reading(input logic [CNT_W-1:0] value);
		longint incoming, current, diff, weight, moved, lead;
		reading_t r;
		if (!shadow_primed) begin
			shadow_smoothed = value;
			shadow_held = value;
			shadow_primed = 1'b1;
		end else begin
			incoming = value;
			current = shadow_smoothed;
			diff = incoming - current;
			weight = smoothing_weight(diff < 0 ? -diff : diff);
			// Arithmetic shift floors negative products, as the block does.
			moved = current + ((diff * weight) >>> WEIGHT_SHIFT);
			shadow_smoothed = moved[CNT_W-1:0];
			current = shadow_smoothed;
			lead = shadow_held;
			lead = current - lead;
			if (lead < 0)
				lead = -lead;
			if (lead > longint'(shadow_cfg.dead_band)) begin
				shadow_held = shadow_smoothed;
				held_moves++;
			end
		end
		r.count = shadow_held;
		r.filtered_units = count_to_units(shadow_held);
		r.raw_units = count_to_units(value);
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_writes++;
		case (index)
			REG_ERROR_LOW:     shadow_cfg.error_low = value;
			REG_ERROR_HIGH:    shadow_cfg.error_high = value;
			REG_WEIGHT_MIN:    shadow_cfg.weight_min = value[WEIGHT_W-1:0];
			REG_WEIGHT_MAX:    shadow_cfg.weight_max = value[WEIGHT_W-1:0];
			REG_DEAD_BAND:     shadow_cfg.dead_band = value;
			REG_ZERO_OFFSET:   shadow_cfg.zero_offset = value;
			REG_UNITS_DIVISOR: shadow_cfg.units_divisor = value;
			default: ;
		endcase
	endtask

	// Offers one sample, waits for its transaction, then idles for the given gap.
	// With no gap, valid stays high for the next sample.
	task automatic send_sample(input logic [CNT_W-1:0] value, input int gap);
		in_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_readings.push_back(predict_reading(value));
		samples_sent++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_relative(input longint delta, input int gap);
		longint target;
		target = shadow_smoothed;
		target = target + delta;
		if (target < 0)
			target = 0;
		if (target > COUNT_TOP)
			target = COUNT_TOP;
		send_sample(target[CNT_W-1:0], gap);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void compare_field(input string field, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: result transaction with no sample pending, count %h",
					$time, filtered_count);
				mismatches++;
			end else begin
				want = expected_readings.pop_front();
				compare_field("filtered_count", want.count, filtered_count);
				compare_field("filtered_units", want.filtered_units, filtered_units);
				compare_field("raw_units", want.raw_units, raw_units);
				results_checked++;
			end
		end
	end

	// Receiver side: random stall runs, or one long hold when the test asks for it.
	always begin : receiver_pacing
		int run;
		@(posedge clk);
		if (hold_request) begin
			out_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			out_stall <= 1'b0;
			hold_request <= 1'b0;
		end else if (!pace_enable) begin
			out_stall <= 1'b0;
		end else begin
			run = pick_gap();
			out_stall <= ($urandom_range(0, 99) < 35);
			repeat (run) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Reset values still apply: equal thresholds and full weight.
	task automatic test_priming_extremes();
		send_sample(COUNT_MAX, pick_gap());
		send_sample('0, pick_gap());
		send_sample(24'h800000, pick_gap());
		send_sample(24'h7FFFFF, pick_gap());
		send_sample(24'h000001, pick_gap());
		settle();
	endtask

	task automatic test_weight_interpolation();
		write_reg(REG_ERROR_LOW, 24'd100);
		write_reg(REG_ERROR_HIGH, 24'd1100);
		write_reg(REG_WEIGHT_MIN, 24'd16);
		write_reg(REG_WEIGHT_MAX, 24'd240);
		send_relative(100, pick_gap());
		send_relative(-101, pick_gap());
		send_relative(-1099, pick_gap());
		send_relative(1100, pick_gap());
		settle();
		// Falling weight: the span between the weights is negative.
		write_reg(REG_WEIGHT_MIN, 24'd240);
		write_reg(REG_WEIGHT_MAX, 24'd16);
		send_relative(500, pick_gap());
		settle();
		write_reg(REG_WEIGHT_MIN, 24'd0);
		write_reg(REG_WEIGHT_MAX, 24'd0);
		send_relative(1000, pick_gap());
		settle();
	endtask

	task automatic test_reversed_thresholds();
		write_reg(REG_ERROR_LOW, 24'd5000);
		write_reg(REG_ERROR_HIGH, 24'd100);
		write_reg(REG_WEIGHT_MIN, 24'd32);
		write_reg(REG_WEIGHT_MAX, 24'd200);
		send_relative(3000, pick_gap());
		send_relative(-6000, pick_gap());
		send_relative(100, pick_gap());
		settle();
		write_reg(REG_ERROR_LOW, COUNT_MAX);
		write_reg(REG_ERROR_HIGH, COUNT_MAX);
		send_relative(50, pick_gap());
		settle();
	endtask

	task automatic test_dead_band();
		write_reg(REG_DEAD_BAND, COUNT_MAX);
		send_relative(2000, pick_gap());
		send_relative(-3000, pick_gap());
		settle();
		write_reg(REG_DEAD_BAND, 24'd300);
		send_relative(250, pick_gap());
		send_relative(1000, pick_gap());
		settle();
	endtask

	task automatic test_unit_conversion();
		write_reg(REG_ZERO_OFFSET, 24'h800000);
		write_reg(REG_UNITS_DIVISOR, 24'd0);
		send_sample(24'h123456, pick_gap());
		settle();
		write_reg(REG_ZERO_OFFSET, COUNT_MAX);
		write_reg(REG_UNITS_DIVISOR, 24'd1);
		send_sample('0, pick_gap());
		settle();
		write_reg(REG_UNITS_DIVISOR, COUNT_MAX);
		send_sample('0, pick_gap());
		settle();
		write_reg(REG_ZERO_OFFSET, 24'd12345);
		write_reg(REG_UNITS_DIVISOR, 24'd7);
		send_sample(24'd100, pick_gap());
		settle();
	endtask

	task automatic test_register_masking();
		write_reg(REG_UNUSED, 24'h5A5A5A);
		write_reg(REG_WEIGHT_MIN, 24'hABCD00);
		write_reg(REG_WEIGHT_MAX, 24'h5A5AFF);
		write_reg(REG_ERROR_LOW, 24'd0);
		write_reg(REG_ERROR_HIGH, 24'd1000);
		send_relative(500, pick_gap());
		send_relative(-20, pick_gap());
		settle();
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_output_hold();
		hold_request <= 1'b1;
		for (int i = 0; i < BURST_SAMPLES; i++)
			send_relative(longint'($urandom_range(0, 4000)) - 2000, 0);
		settle();
	endtask

	function automatic logic [CNT_W-1:0] pick_count(input int phase, input int typical);
		if (phase == 0)
			return COUNT_MAX;
		if (phase == 1)
			return '0;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COUNT_MAX;
			2, 3: return $urandom();
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	task automatic send_random_sample();
		longint span;
		int roll;
		roll = $urandom_range(0, 99);
		span = (shadow_cfg.error_high > shadow_cfg.error_low) ?
			shadow_cfg.error_high : shadow_cfg.error_low;
		span = span + 300;
		if (span > COUNT_TOP)
			span = COUNT_TOP;
		// Most samples land near the smoothed value so the weight ramp gets used.
		if (roll < 60)
			send_relative(longint'($urandom_range(0, 2 * span)) - span, pick_gap());
		else if (roll < 65)
			send_relative(0, pick_gap());
		else if (roll < 75)
			send_sample($urandom_range(0, 1) ? COUNT_MAX : '0, pick_gap());
		else
			send_sample($urandom(), pick_gap());
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pace_enable <= (phase % 4 != 3);
			write_reg(REG_ERROR_LOW, pick_count(phase, 4000));
			write_reg(REG_ERROR_HIGH, pick_count(phase, 4000));
			write_reg(REG_WEIGHT_MIN, pick_count(phase, 255));
			write_reg(REG_WEIGHT_MAX, pick_count(phase, 255));
			write_reg(REG_DEAD_BAND, pick_count(phase, 400));
			write_reg(REG_ZERO_OFFSET, pick_count(phase, 16777215));
			write_reg(REG_UNITS_DIVISOR, pick_count(phase, 3000));
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_UNUSED, $urandom());
			for (int i = 0; i < PHASE_SAMPLES; i++)
				send_random_sample();
			settle();
		end
		pace_enable <= 1'b1;
	endtask

	initial begin
		shadow_cfg = '0;
		shadow_cfg.weight_min = WEIGHT_RESET;
		shadow_cfg.weight_max = WEIGHT_RESET;
		shadow_cfg.units_divisor = DIVISOR_RESET;
		shadow_primed = 1'b0;
		shadow_smoothed = '0;
		shadow_held = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_priming_extremes();
		test_weight_interpolation();
		test_reversed_thresholds();
		test_dead_band();
		test_unit_conversion();
		test_register_masking();
		test_output_hold();
		test_random_settings();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d samples over %0d register writes",
			results_checked, samples_sent, cfg_writes);
		$display("and %0d random settings; the weight was interpolated for %0d samples%s%0d times.",
			RANDOM_PHASES, interpolated, " and the held count moved ", held_moves);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
